// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/qte_pkg.sv -----
// ---------------------------------------------------------------------------
// qte_pkg
// Beat types, fixed-point constants and the arctangent table.
// ---------------------------------------------------------------------------
package qte_pkg;

    localparam int COMP_W   = 16;
    localparam int ANGLE_W  = 16;
    localparam int SQ_STEPS = 31;

    // pi/2 and degree scale (23040/pi * 2^16), radians Q30
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [28:0]        DEG_SCALE   = 29'd480631834;

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } out_t;

    // round(atan(2^-i) * 2^30)
    function automatic logic signed [33:0] atan_q30(input int unsigned idx);
        logic signed [33:0] v;
        unique case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/quaternion_to_euler_angles_top.sv -----
// ---------------------------------------------------------------------------
// Quaternion to Euler angles (ZYX)
// Pipelined products, digit-recurrence square root and three CORDIC
// vectoring units giving roll, pitch and yaw per quaternion.
// ---------------------------------------------------------------------------
//  channel | signals                       | beat
//  --------+-------------------------------+--------------------------------
//  in      | in_valid  in_ready  in_data   | one quaternion (w, x, y, z)
//  out     | out_valid out_ready out_data  | roll, pitch, yaw angles
//  cfg     | cfg_valid cfg_ready cfg_data  | unit select, 1 = radians Q3.12
//
// One quaternion enters per cycle while the pipe is not frozen; the pipe holds
// the 31 square-root digit stages and one stage per CORDIC iteration.
// Reset clears all valid bits and selects radians.
// A held output beat parks the next finished beat in a skid register; the
// whole pipe then freezes from the next cycle, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qte_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qte_pkg::out_t  out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);
    import qte_pkg::*;

    localparam int CR_BASE = 2 + SQ_STEPS + 1;
    localparam int CV1     = CR_BASE + CORDIC_STEPS + 1;
    localparam int CV2     = CV1 + 1;
    localparam int LAST    = CV2 + 1;
    localparam int DEPTH   = LAST + 1;

    typedef struct packed {
        logic signed [31:0] wx, yz, xx, yy, wy, zx, wz, xy;
    } prod_t;

    typedef struct packed {
        logic signed [33:0] t0, t1, t3, t4;
        logic signed [31:0] t30;
    } term_t;

    typedef struct packed {
        logic signed [33:0] t0, t1, t3, t4;
        logic signed [31:0] t30;
        logic [30:0]        root;
        logic [61:0]        rem;
    } sq_t;

    typedef struct packed {
        logic               zero;
        logic signed [37:0] x;
        logic signed [37:0] y;
        logic signed [33:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [46:0] pp_hi;
        logic [45:0]        pp_lo;
        logic signed [33:0] ang;
    } cv1_t;

    typedef struct packed {
        logic signed [63:0] deg;
        logic signed [33:0] ang;
    } cv2_t;

    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic             rad_reg;
    prod_t            prod_reg;
    term_t            term_reg;
    sq_t              sq_reg [SQ_STEPS+1];
    vec_t             cr_reg [CORDIC_STEPS+1][3];
    cv1_t             cv1_reg [3];
    cv2_t             cv2_reg [3];
    out_t             last_reg;
    out_t             out_data_reg;
    out_t             skid_data_reg;
    logic             out_v_reg;
    logic             skid_v_reg;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] r);
        logic signed [15:0] v;
        if (r > 18'sd32767)
            v = 16'sh7fff;
        else if (r < -18'sd32768)
            v = 16'sh8000;
        else
            v = r[15:0];
        return v;
    endfunction

    function automatic logic signed [15:0] to_rad(input logic signed [33:0] a);
        logic signed [34:0] s;
        s = {a[33], a} + 35'sd131072;
        return sat16({s[34], s[34:18]});
    endfunction

    function automatic logic signed [15:0] to_deg(input logic signed [63:0] d);
        logic signed [63:0] s;
        s = d + (64'sd1 <<< 45);
        return sat16(s[63:46]);
    endfunction

    function automatic vec_t prerot(input logic signed [33:0] yi,
                                    input logic signed [33:0] xi);
        vec_t               v;
        logic signed [37:0] xe;
        logic signed [37:0] ye;
        xe = {{4{xi[33]}}, xi};
        ye = {{4{yi[33]}}, yi};
        v.zero = (xi == 34'sd0) && (yi == 34'sd0);
        if (xe < 0) begin
            if (ye >= 0)
            begin
                v.x = ye;
                v.y = -xe;
                v.z = HALF_PI_Q30;
            end
            else
            begin
                v.x = -ye;
                v.y = xe;
                v.z = -HALF_PI_Q30;
            end
        end
        else
        begin
            v.x = xe;
            v.y = ye;
            v.z = 34'sd0;
        end
        return v;
    endfunction

    assign en        = !skid_v_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

    // unit select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rad_reg <= 1'b1;
        else if (cfg_valid)
            rad_reg <= cfg_data;
    end

    // valid bits advance with the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // products, Q30
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg.wx <= 32'(in_data.quat_w) * 32'(in_data.quat_x);
            prod_reg.yz <= 32'(in_data.quat_y) * 32'(in_data.quat_z);
            prod_reg.xx <= 32'(in_data.quat_x) * 32'(in_data.quat_x);
            prod_reg.yy <= 32'(in_data.quat_y) * 32'(in_data.quat_y);
            prod_reg.wy <= 32'(in_data.quat_w) * 32'(in_data.quat_y);
            prod_reg.zx <= 32'(in_data.quat_z) * 32'(in_data.quat_x);
            prod_reg.wz <= 32'(in_data.quat_w) * 32'(in_data.quat_z);
            prod_reg.xy <= 32'(in_data.quat_x) * 32'(in_data.quat_y);
        end
    end

    // terms; pitch argument clamped to [-1, 1]
    logic signed [33:0] t2_raw;
    assign t2_raw = 34'(2) * (34'(prod_reg.wy) - 34'(prod_reg.zx));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg.t0 <= 34'(2) * (34'(prod_reg.wx) + 34'(prod_reg.yz));
            term_reg.t1 <= (34'sd1 <<< 30)
                           - 34'(2) * (34'(prod_reg.xx) + 34'(prod_reg.yy));
            term_reg.t3 <= 34'(2) * (34'(prod_reg.wz) + 34'(prod_reg.xy));
            term_reg.t4 <= (34'sd1 <<< 30) - 34'(2) * 34'(prod_reg.yy);
            if (t2_raw > (34'sd1 <<< 30))
                term_reg.t30 <= 32'sd1 <<< 30;
            else if (t2_raw < -(34'sd1 <<< 30))
                term_reg.t30 <= -(32'sd1 <<< 30);
            else
                term_reg.t30 <= t2_raw[31:0];
        end
    end

    // z squared is needed for yaw; keep it alongside
    logic signed [31:0] zz_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            zz_reg <= 32'(in_data.quat_z) * 32'(in_data.quat_z);
    end

    logic signed [31:0] zz_d_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            zz_d_reg <= zz_reg;
    end

    // radicand 2^60 - t30^2
    logic signed [63:0] t30_sq;
    assign t30_sq = 64'(term_reg.t30) * 64'(term_reg.t30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].t0   <= term_reg.t0;
            sq_reg[0].t1   <= term_reg.t1;
            sq_reg[0].t3   <= term_reg.t3;
            sq_reg[0].t4   <= term_reg.t4 - 34'(2) * 34'(zz_d_reg);
            sq_reg[0].t30  <= term_reg.t30;
            sq_reg[0].root <= '0;
            sq_reg[0].rem  <= 62'((64'sd1 <<< 60) - t30_sq);
        end
    end

    // one root bit per stage, most significant first
    for (genvar j = 1; j <= SQ_STEPS; j++)
    begin : g_sqrt
        localparam int K = SQ_STEPS - j;
        logic [61:0] trial;
        sq_t         sq_next;
        assign trial = ({31'd0, sq_reg[j-1].root} << (K + 1)) + (62'd1 << (2 * K));
        always_comb
        begin
            sq_next = sq_reg[j-1];
            if (sq_reg[j-1].rem >= trial)
            begin
                sq_next.rem  = sq_reg[j-1].rem - trial;
                sq_next.root = sq_reg[j-1].root | (31'd1 << K);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[j] <= sq_next;
        end
    end

    // quadrant fold for roll, pitch, yaw
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[0][0] <= prerot(sq_reg[SQ_STEPS].t0, sq_reg[SQ_STEPS].t1);
            cr_reg[0][1] <= prerot(34'(sq_reg[SQ_STEPS].t30),
                                   {3'd0, sq_reg[SQ_STEPS].root});
            cr_reg[0][2] <= prerot(sq_reg[SQ_STEPS].t3, sq_reg[SQ_STEPS].t4);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            vec_t               cur;
            logic signed [37:0] dx;
            logic signed [37:0] dy;
            logic               pos;
            assign cur = cr_reg[i][a];
            assign dx  = cur.y >>> i;
            assign dy  = cur.x >>> i;
            assign pos = !cur.y[37] && (cur.y != 38'sd0);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cr_reg[i+1][a].zero <= cur.zero;
                    if (pos)
                    begin
                        cr_reg[i+1][a].x <= cur.x + dx;
                        cr_reg[i+1][a].y <= cur.y - dy;
                        cr_reg[i+1][a].z <= cur.z + atan_q30(i);
                    end
                    else
                    begin
                        cr_reg[i+1][a].x <= cur.x - dx;
                        cr_reg[i+1][a].y <= cur.y + dy;
                        cr_reg[i+1][a].z <= cur.z - atan_q30(i);
                    end
                end
            end
        end
    end

    // degree scaling split into two 17-bit halves
    for (genvar a = 0; a < 3; a++)
    begin : g_conv
        logic signed [33:0] ang;
        assign ang = cr_reg[CORDIC_STEPS][a].zero ? 34'sd0 : cr_reg[CORDIC_STEPS][a].z;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cv1_reg[a].ang   <= ang;
                cv1_reg[a].pp_hi <= $signed(ang[33:17]) * $signed({1'b0, DEG_SCALE});
                cv1_reg[a].pp_lo <= ang[16:0] * DEG_SCALE;
                cv2_reg[a].ang   <= cv1_reg[a].ang;
                cv2_reg[a].deg   <= ({{17{cv1_reg[a].pp_hi[46]}}, cv1_reg[a].pp_hi} <<< 17)
                                    + $signed({18'd0, cv1_reg[a].pp_lo});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg.roll_angle  <= rad_reg ? to_rad(cv2_reg[0].ang) : to_deg(cv2_reg[0].deg);
            last_reg.pitch_angle <= rad_reg ? to_rad(cv2_reg[1].ang) : to_deg(cv2_reg[1].deg);
            last_reg.yaw_angle   <= rad_reg ? to_rad(cv2_reg[2].ang) : to_deg(cv2_reg[2].deg);
        end
    end

    // output register with skid slot
    logic last_v;
    logic out_free;
    assign last_v   = en && vld_reg[LAST];
    assign out_free = !out_v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg  <= skid_v_reg || last_v;
            skid_v_reg <= 1'b0;
        end
        else if (last_v)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= skid_v_reg ? skid_data_reg : last_reg;
        else if (last_v)
            skid_data_reg <= last_reg;
    end

    `ASSERT_NEVER(a_skid_without_out, clk, rst_n, skid_v_reg && !out_v_reg, "skid without out")
    `ASSERT_PROP(a_park_in_skid, clk, rst_n, (out_v_reg && !out_ready && last_v) |=> skid_v_reg, "not parked")
    `ASSERT_PROP(a_freeze_pipe, clk, rst_n, !en |=> $stable(vld_reg), "pipe moved while frozen")

endmodule
